>>> hw/rtl/hte_pkg.sv
// Shared types, character codes and helpers for the hex text byte extractor.
package hte_pkg;

  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_X_LOWER = 8'h78;
  localparam logic [7:0] CHAR_X_UPPER = 8'h58;

  localparam logic [7:0] BYTE_COUNT_RESET = 8'd2;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       first_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic [7:0] table_index;
    logic       overflow;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] num;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.valid  = 1'b0;
    d.nibble = 4'd0;
    case (c) inside
      [8'h30:8'h39]: begin
        d.valid  = 1'b1;
        d.nibble = c[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        d.valid  = 1'b1;
        d.nibble = 4'(c[3:0] + 4'd9);
      end
      default: begin
        d.valid  = 1'b0;
        d.nibble = 4'd0;
      end
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/hte_if.sv
// Valid/ready channel interfaces for character items and result items.
interface hte_in_if;
  logic              valid;
  logic              ready;
  hte_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hte_out_if;
  logic               valid;
  logic               ready;
  hte_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/hex_text_byte_extractor_top.sv
// Each result item is registered in the result queue when its character item is accepted.
// Input takes one character item per cycle while the queue holds at most two items;
// a character yielding a byte and the end result queues both for the one-item port.
// The four-entry result queue sets how far the output side may stall before input stops.
// Reset (synchronous, active low) empties the queue and returns the parser to idle
// with the next table index at two.
module hex_text_byte_extractor_top #(
  parameter int TABLE_DEPTH = 128
) (
  input logic clk,
  input logic rst_n,
  hte_in_if.sink    in_ch,
  hte_out_if.source out_ch
);

  hte_pkg::push_t push;
  logic           can_take;
  logic           step;

  assign in_ch.ready = can_take;
  assign step        = in_ch.valid && can_take;

  hte_parser #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_item (in_ch.data),
    .push    (push)
  );

  hte_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (step),
    .push     (push),
    .can_take (can_take),
    .rd_valid (out_ch.valid),
    .rd_ready (out_ch.ready),
    .rd_item  (out_ch.data)
  );

endmodule

>>> hw/rtl/hte_parser.sv
// Token and comment parser: state registers and the results of one character.
module hte_parser #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  hte_pkg::in_item_t in_item,
  output hte_pkg::push_t    push
);

  typedef enum logic [1:0] {PH_IDLE, PH_ZERO, PH_X, PH_HIGH} phase_t;

  localparam logic [7:0] DEPTH_LIMIT = 8'(TABLE_DEPTH);

  phase_t     phase_r, phase_nxt, phase_cur;
  logic [1:0] level_r, level_nxt, level_cur;
  logic [3:0] high_r, high_nxt, high_cur;
  logic [7:0] count_r, count_nxt, count_cur;

  hte_pkg::hex_digit_t dig;
  logic                have_byte;
  logic                byte_ovf;
  logic [7:0]          byte_idx;
  logic [7:0]          byte_val;
  hte_pkg::out_item_t  byte_item;
  hte_pkg::out_item_t  end_item;

  always_comb begin
    phase_cur = in_item.first_char ? PH_IDLE : phase_r;
    level_cur = in_item.first_char ? 2'd0 : level_r;
    high_cur  = in_item.first_char ? 4'd0 : high_r;
    count_cur = in_item.first_char ? hte_pkg::BYTE_COUNT_RESET : count_r;
    dig       = hte_pkg::hex_decode(in_item.char_byte);

    phase_nxt = phase_cur;
    level_nxt = level_cur;
    high_nxt  = high_cur;
    count_nxt = count_cur;
    have_byte = 1'b0;
    byte_ovf  = count_cur >= DEPTH_LIMIT;
    byte_idx  = count_cur;
    byte_val  = {high_cur, dig.nibble};

    if (in_item.char_byte == hte_pkg::CHAR_CR || in_item.char_byte == hte_pkg::CHAR_LF) begin
      level_nxt = 2'd0;
      phase_nxt = PH_IDLE;
    end else if (in_item.char_byte == hte_pkg::CHAR_SLASH) begin
      if (level_cur != 2'd3) begin
        level_nxt = 2'(level_cur + 2'd1);
      end
      phase_nxt = PH_IDLE;
    end else if (dig.valid) begin
      if (level_cur <= 2'd1) begin
        if (phase_cur == PH_IDLE && in_item.char_byte == hte_pkg::CHAR_ZERO) begin
          phase_nxt = PH_ZERO;
        end else if (phase_cur == PH_X) begin
          high_nxt  = dig.nibble;
          phase_nxt = PH_HIGH;
        end else if (phase_cur == PH_HIGH) begin
          have_byte = 1'b1;
          if (!byte_ovf) begin
            count_nxt = 8'(count_cur + 8'd1);
          end
          phase_nxt = PH_IDLE;
        end
      end
    end else if (in_item.char_byte == hte_pkg::CHAR_X_LOWER ||
                 in_item.char_byte == hte_pkg::CHAR_X_UPPER) begin
      if (phase_cur == PH_ZERO) begin
        phase_nxt = PH_X;
      end
    end else begin
      if (level_cur == 2'd1) begin
        level_nxt = 2'd0;
      end
      phase_nxt = PH_IDLE;
    end

    byte_item.kind        = hte_pkg::KIND_BYTE;
    byte_item.byte_value  = byte_val;
    byte_item.table_index = byte_idx;
    byte_item.overflow    = byte_ovf;
    byte_item.last_of_run = ~in_item.last_char;

    end_item.kind        = hte_pkg::KIND_END;
    end_item.byte_value  = 8'd0;
    end_item.table_index = count_nxt;
    end_item.overflow    = 1'b0;
    end_item.last_of_run = 1'b1;

    push.num   = 2'({1'b0, have_byte} + {1'b0, in_item.last_char});
    push.item0 = have_byte ? byte_item : end_item;
    push.item1 = end_item;

    if (in_item.last_char) begin
      phase_nxt = PH_IDLE;
      level_nxt = 2'd0;
      high_nxt  = 4'd0;
      count_nxt = hte_pkg::BYTE_COUNT_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      level_r <= 2'd0;
      high_r  <= 4'd0;
      count_r <= hte_pkg::BYTE_COUNT_RESET;
    end else if (step) begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      high_r  <= high_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/hte_out_queue.sv
// Four-entry result queue taking up to two items per cycle; one out if ready.
module hte_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  hte_pkg::push_t      push,
  output logic                can_take,
  output logic                rd_valid,
  input  logic                rd_ready,
  output hte_pkg::out_item_t  rd_item
);

  hte_pkg::out_item_t mem [hte_pkg::OQ_DEPTH];

  logic [hte_pkg::OQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hte_pkg::OQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hte_pkg::OQ_CNT_W-1:0] count_r, count_nxt;
  logic [1:0]                   num_in;
  logic                         pop;

  assign num_in   = wr_en ? push.num : 2'd0;
  assign rd_valid = count_r != '0;
  assign rd_item  = mem[rd_ptr_r];
  assign pop      = rd_valid && rd_ready;
  assign can_take = count_r <= hte_pkg::OQ_CNT_W'(hte_pkg::OQ_DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = hte_pkg::OQ_PTR_W'(wr_ptr_r + hte_pkg::OQ_PTR_W'(num_in));
    rd_ptr_nxt = hte_pkg::OQ_PTR_W'(rd_ptr_r + hte_pkg::OQ_PTR_W'(pop));
    count_nxt  = hte_pkg::OQ_CNT_W'(count_r + hte_pkg::OQ_CNT_W'(num_in)
                                    - hte_pkg::OQ_CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (num_in != 2'd0) begin
      mem[wr_ptr_r] <= push.item0;
    end
    if (num_in == 2'd2) begin
      mem[hte_pkg::OQ_PTR_W'(wr_ptr_r + 1'b1)] <= push.item1;
    end
  end

endmodule
